// ===== rtl/cds_pkg.sv =====
package cds_pkg;

  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MULY,
    OP_SETMOD,
    OP_DSHORT,
    OP_REMINIT,
    OP_DITER,
    OP_MITER,
    OP_MULL,
    OP_REM12,
    OP_MFIN,
    OP_YSUB,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_UNDER,
    C_YEAR,
    C_MONTH,
    C_DSHORT,
    C_DCONT,
    C_MCONT,
    C_OUTBUSY,
    C_NOIN
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  localparam logic [1:0] MODE_DAYS   = 2'd0;
  localparam logic [1:0] MODE_WEEKS  = 2'd1;
  localparam logic [1:0] MODE_MONTHS = 2'd2;
  localparam logic [1:0] MODE_YEARS  = 2'd3;

  // reciprocals: y / 400 = (y * K400) >> 23, n / 12 = (n * K12) >> 19, exact below 2^15
  localparam logic [15:0] K400      = 16'd20972;
  localparam logic [15:0] K12       = 16'd43691;
  localparam logic [17:0] DAYS_400Y = 18'd146097;

  localparam upc_t PC_MULY    = 4'd0;
  localparam upc_t PC_SETMOD  = 4'd1;
  localparam upc_t PC_DISPM   = 4'd2;
  localparam upc_t PC_DISPD   = 4'd3;
  localparam upc_t PC_REMINIT = 4'd4;
  localparam upc_t PC_DITER   = 4'd5;
  localparam upc_t PC_DSHORT  = 4'd6;
  localparam upc_t PC_MITER   = 4'd7;
  localparam upc_t PC_MULL    = 4'd8;
  localparam upc_t PC_REM12   = 4'd9;
  localparam upc_t PC_MFIN    = 4'd10;
  localparam upc_t PC_YSUB    = 4'd13;
  localparam upc_t PC_OUT     = 4'd14;
  localparam upc_t PC_IDLE    = 4'd15;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    unique case (pc)
      PC_MULY:    w = '{OP_MULY,    C_UNDER,   PC_OUT};
      PC_SETMOD:  w = '{OP_SETMOD,  C_YEAR,    PC_YSUB};
      PC_DISPM:   w = '{OP_NOP,     C_MONTH,   PC_MITER};
      PC_DISPD:   w = '{OP_NOP,     C_DSHORT,  PC_DSHORT};
      PC_REMINIT: w = '{OP_REMINIT, C_NEVER,   PC_IDLE};
      PC_DITER:   w = '{OP_DITER,   C_DCONT,   PC_DITER};
      PC_DSHORT:  w = '{OP_DSHORT,  C_ALWAYS,  PC_OUT};
      PC_MITER:   w = '{OP_MITER,   C_MCONT,   PC_MITER};
      PC_MULL:    w = '{OP_MULL,    C_UNDER,   PC_OUT};
      PC_REM12:   w = '{OP_REM12,   C_NEVER,   PC_IDLE};
      PC_MFIN:    w = '{OP_MFIN,    C_ALWAYS,  PC_OUT};
      PC_YSUB:    w = '{OP_YSUB,    C_NEVER,   PC_IDLE};
      PC_OUT:     w = '{OP_OUT,     C_OUTBUSY, PC_OUT};
      PC_IDLE:    w = '{OP_LOAD,    C_NOIN,    PC_IDLE};
      default:    w = '{OP_NOP,     C_ALWAYS,  PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/calendar_date_subtract_top.sv =====
// channel  | ports                                               | dir
// ---------+-----------------------------------------------------+-----
// in       | in_valid/in_ready, mode, amount, start day/month/yr | in
// out      | out_valid/out_ready, end day/month/year, underflow  | out
//
// Years: a direct subtract. Months: a loop of clamped month steps, then a finish step.
// Days/weeks: a direct subtract if the day stays in its month, else a loop that steps back
// a month or a year at a time (400 years in one step), run by the microcode loop over the
// shared month/year step unit. A start year of zero goes straight to the output step.
// rst_n is synchronous; after it the sequencer waits at its idle step. A new beat is taken
// while a result waits on out; the output step holds only while that result is not taken.
module calendar_date_subtract_top
  import cds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [14:0] in_amount,
  input  logic [4:0]  in_start_day,
  input  logic [3:0]  in_start_month,
  input  logic [14:0] in_start_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_end_day,
  output logic [3:0]  out_end_month,
  output logic [14:0] out_end_year,
  output logic        out_underflow
);

  upc_t        pc_r, pc_nxt;
  uword_t      uw;
  logic        take;

  logic [1:0]  mode_r, mode_nxt;
  logic [4:0]  d_r, d_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [14:0] y_r, y_nxt;
  logic [8:0]  ymod_r, ymod_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [14:0] left_r, left_nxt;
  logic [11:0] q_r, q_nxt;
  logic        under_r, under_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [14:0] out_year_r, out_year_nxt;
  logic        out_under_r, out_under_nxt;

  logic        in_fire, out_free, leap, wrap, rem_ge_d, at_dec_year, big, mcont;
  logic [3:0]  pm, mi, r12, m_fin;
  logic [4:0]  pm_len;
  logic [14:0] y_dec, mul_a, q400, q12;
  logic [8:0]  ymod_dec;
  logic [17:0] ylen;
  logic [30:0] prod;
  logic [11:0] q_mul;
  logic        borrow, fin_under;
  logic [15:0] y_fin;
  logic        is_mull;

  assign uw       = ucode(pc_r);
  assign in_ready = (pc_r == PC_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign leap = (y_r[1:0] == 2'b00) && (ymod_r != 9'd100) && (ymod_r != 9'd200) &&
                (ymod_r != 9'd300);
  assign wrap     = (m_r == 4'd1);
  assign pm       = wrap ? 4'd12 : m_r - 4'd1;
  assign pm_len   = month_len(pm, leap);
  assign y_dec    = y_r - 15'd1;
  assign ymod_dec = (ymod_r == 9'd0) ? 9'd399 : ymod_r - 9'd1;

  assign rem_ge_d    = rem_r >= {13'd0, d_r};
  assign ylen        = leap ? 18'd366 : 18'd365;
  assign at_dec_year = (m_r == 4'd12) && (rem_r >= ylen);
  assign big         = rem_r >= DAYS_400Y;
  assign mcont       = !under_r && (left_r != 15'd0) && (d_r > 5'd28);

  // shared constant multiplier: year / 400 or month count / 12
  assign is_mull = (uw.op == OP_MULL);
  assign mul_a   = is_mull ? left_r : y_r;
  assign prod    = 31'(mul_a) * 31'(is_mull ? K12 : K400);
  assign q_mul   = is_mull ? prod[30:19] : {5'd0, prod[29:23]};
  assign q400    = (15'(q_r) << 8) + (15'(q_r) << 7) + (15'(q_r) << 4);
  assign q12     = (15'(q_r) << 3) + (15'(q_r) << 2);

  assign mi        = m_r - 4'd1;
  assign r12       = left_r[3:0];
  assign borrow    = mi < r12;
  assign m_fin     = borrow ? mi + 4'd13 - r12 : mi + 4'd1 - r12;
  assign y_fin     = {1'b0, y_r} - {4'd0, q_r} - {15'd0, borrow};
  assign fin_under = y_fin[15] || (y_fin == 16'd0);

  always_comb begin
    case (uw.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_UNDER:   take = under_r;
      C_YEAR:    take = (mode_r == MODE_YEARS);
      C_MONTH:   take = (mode_r == MODE_MONTHS);
      C_DSHORT:  take = (rem_r == 18'd0) || !rem_ge_d;
      C_DCONT:   take = !under_r && rem_ge_d;
      C_MCONT:   take = mcont;
      C_OUTBUSY: take = !out_free;
      C_NOIN:    take = !in_valid;
      default:   take = 1'b0;
    endcase
    // the idle step is the last address; falling through wraps to step 0
    pc_nxt = take ? uw.target : pc_r + 4'd1;
  end

  always_comb begin
    mode_nxt      = mode_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    y_nxt         = y_r;
    ymod_nxt      = ymod_r;
    rem_nxt       = rem_r;
    left_nxt      = left_r;
    q_nxt         = q_r;
    under_nxt     = under_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_under_nxt = out_under_r;
    case (uw.op)
      OP_LOAD: begin
        if (in_fire) begin
          mode_nxt  = in_mode;
          left_nxt  = in_amount;
          d_nxt     = in_start_day;
          y_nxt     = in_start_year;
          under_nxt = (in_start_year == 15'd0);
          if (in_start_month == 4'd0) begin
            m_nxt = 4'd1;
          end else if (in_start_month > 4'd12) begin
            m_nxt = 4'd12;
          end else begin
            m_nxt = in_start_month;
          end
          if (in_mode == MODE_WEEKS) begin
            rem_nxt = {in_amount, 3'b000} - {3'b000, in_amount};
          end else begin
            rem_nxt = {3'b000, in_amount};
          end
        end
      end
      OP_MULY, OP_MULL: begin
        q_nxt = q_mul;
      end
      OP_SETMOD: begin
        ymod_nxt = 9'(y_r - q400);
      end
      OP_DSHORT: begin
        d_nxt = d_r - rem_r[4:0];
      end
      OP_REMINIT: begin
        rem_nxt = rem_r - {13'd0, d_r};
        m_nxt   = pm;
        d_nxt   = pm_len;
        if (wrap) begin
          y_nxt    = y_dec;
          ymod_nxt = ymod_dec;
          if (y_r == 15'd1) begin
            under_nxt = 1'b1;
          end
        end
      end
      OP_DITER: begin
        if (!under_r && rem_ge_d) begin
          if (at_dec_year) begin
            if (big) begin
              if (y_r > 15'd400) begin
                y_nxt   = y_r - 15'd400;
                rem_nxt = rem_r - DAYS_400Y;
              end else begin
                under_nxt = 1'b1;
              end
            end else begin
              rem_nxt  = rem_r - ylen;
              y_nxt    = y_dec;
              ymod_nxt = ymod_dec;
              if (y_r == 15'd1) begin
                under_nxt = 1'b1;
              end
            end
          end else begin
            rem_nxt = rem_r - {13'd0, d_r};
            m_nxt   = pm;
            d_nxt   = pm_len;
            if (wrap) begin
              y_nxt    = y_dec;
              ymod_nxt = ymod_dec;
              if (y_r == 15'd1) begin
                under_nxt = 1'b1;
              end
            end
          end
        end
      end
      OP_MITER: begin
        if (mcont) begin
          m_nxt    = pm;
          d_nxt    = (d_r > pm_len) ? pm_len : d_r;
          left_nxt = left_r - 15'd1;
          if (wrap) begin
            y_nxt    = y_dec;
            ymod_nxt = ymod_dec;
            if (y_r == 15'd1) begin
              under_nxt = 1'b1;
            end
          end
        end
      end
      OP_REM12: begin
        left_nxt = left_r - q12;
      end
      OP_MFIN: begin
        m_nxt = m_fin;
        y_nxt = y_fin[14:0];
        if (fin_under) begin
          under_nxt = 1'b1;
        end
      end
      OP_YSUB: begin
        if (left_r >= y_r) begin
          under_nxt = 1'b1;
        end else begin
          y_nxt = y_r - left_r;
        end
      end
      OP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_under_nxt = under_r;
          out_day_nxt   = under_r ? 5'd1 : d_r;
          out_month_nxt = under_r ? 4'd1 : m_r;
          out_year_nxt  = under_r ? 15'd1 : y_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    d_r         <= d_nxt;
    m_r         <= m_nxt;
    y_r         <= y_nxt;
    ymod_r      <= ymod_nxt;
    rem_r       <= rem_nxt;
    left_r      <= left_nxt;
    q_r         <= q_nxt;
    under_r     <= under_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_under_r <= out_under_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_end_day   = out_day_r;
  assign out_end_month = out_month_r;
  assign out_end_year  = out_year_r;
  assign out_underflow = out_under_r;

`ifndef SYNTHESIS
  a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r >= PC_DISPM && pc_r <= PC_MFIN) |-> (ymod_r < 9'd400))
    else $error("year mod 400 tracker out of range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_MITER || pc_r == PC_DITER) |-> (m_r >= 4'd1 && m_r <= 4'd12))
    else $error("month out of range in step loop");

  a_day_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_DITER && !under_r) |-> (d_r >= 5'd28 && d_r <= 5'd31))
    else $error("day loop not at end of a month");

  a_under_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_under_r) |->
      (out_day_r == 5'd1 && out_month_r == 4'd1 && out_year_r == 15'd1))
    else $error("underflow beat not saturated");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_IDLE && !in_valid) |=> (pc_r == PC_IDLE))
    else $error("sequencer left idle without a beat");
`endif

endmodule
